// ===== sv/xdw_pkg.sv =====
// Shared types and constants of the X-drive wheel mixer.
package xdw_pkg;

	// Width of the CORDIC datapath (x, y and residual angle).
	localparam int XW = 34;
	localparam int CORDIC_STEPS = 20;
	localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic signed [XW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
		34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
		34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304
	};

	// Q16 cosine, wheel value and wheel magnitude widths.
	localparam int C_W = 18;
	localparam int W_W = 26;
	localparam int MAG_W = 25;
	// Quotient bits before saturation to the full-scale command.
	localparam int QW = 8;

	// Configuration register indexes and reset values.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEADBAND = 2'd1;
	localparam logic [6:0] MAX_SPEED_RST = 7'd100;
	localparam logic [6:0] DEADBAND_RST = 7'd10;

	typedef enum logic [1:0] {
		MODE_TRANSLATE = 2'd0,
		MODE_ROTATE    = 2'd1,
		MODE_BRAKE     = 2'd2,
		MODE_NO_POS    = 2'd3
	} drive_mode_t;

endpackage

// ===== sv/xdw_ifs.sv =====
// Channel interfaces of the X-drive wheel mixer: commands, results, configuration.
interface xdw_cmd_if #(parameter int AW = 16, parameter int SW = 17);
	logic valid;
	logic ready;
	logic [AW-1:0] heading_angle;
	logic [SW-1:0] speed_fraction;
	logic signed [7:0] rotation_cmd;
	modport source(output valid, heading_angle, speed_fraction, rotation_cmd, input ready);
	modport sink(input valid, heading_angle, speed_fraction, rotation_cmd, output ready);
endinterface

interface xdw_res_if;
	logic valid;
	logic ready;
	logic signed [7:0] front_left_drive;
	logic signed [7:0] front_right_drive;
	logic signed [7:0] rear_left_drive;
	logic signed [7:0] rear_right_drive;
	logic [1:0] drive_mode;
	modport source(output valid, front_left_drive, front_right_drive, rear_left_drive,
		rear_right_drive, drive_mode, input ready);
	modport sink(input valid, front_left_drive, front_right_drive, rear_left_drive,
		rear_right_drive, drive_mode, output ready);
endinterface

interface xdw_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [6:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/xdw_cordic.sv =====
// Pipelined two-lane CORDIC giving Q16 cosines of two turn angles.
module xdw_cordic import xdw_pkg::*; #(
	parameter int SIDE_W = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [31:0] ang_a,
	input  logic [31:0] ang_b,
	input  logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic signed [C_W-1:0] cos_a,
	output logic signed [C_W-1:0] cos_b,
	output logic [SIDE_W-1:0] side_out
);

	// Stage 0 holds the folded angle, stages 1..CORDIC_STEPS the rotations.
	logic signed [XW-1:0] x_s [CORDIC_STEPS+1][2];
	logic signed [XW-1:0] y_s [CORDIC_STEPS+1][2];
	logic signed [XW-1:0] z_s [CORDIC_STEPS+1][2];
	logic neg_s [CORDIC_STEPS+1][2];
	logic v_s [CORDIC_STEPS+2];
	logic [SIDE_W-1:0] side_s [CORDIC_STEPS+2];
	logic signed [C_W-1:0] cos_s [2];

	// Valid bits and sideband advance with the whole pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORDIC_STEPS + 2; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < CORDIC_STEPS + 2; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < CORDIC_STEPS + 2; k++) side_s[k] <= side_s[k-1];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [31:0] ang;
		logic [31:0] wrap;
		logic [31:0] t;
		assign ang  = (l == 0) ? ang_a : ang_b;
		assign wrap = ang + 32'h4000_0000;
		// Angles in the left half-plane turn by half a turn and flip the sign.
		assign t    = wrap[31] ? ang + 32'h8000_0000 : ang;

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[0][l]   <= CORDIC_X0;
				y_s[0][l]   <= '0;
				z_s[0][l]   <= {{(XW-32){t[31]}}, t};
				neg_s[0][l] <= wrap[31];
			end
		end

		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
			logic signed [XW-1:0] dx;
			logic signed [XW-1:0] dy;
			assign dx = y_s[i][l] >>> i;
			assign dy = x_s[i][l] >>> i;
			// One micro-rotation toward a zero residual angle.
			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_s[i][l][XW-1]) begin
						x_s[i+1][l] <= x_s[i][l] - dx;
						y_s[i+1][l] <= y_s[i][l] + dy;
						z_s[i+1][l] <= z_s[i][l] - ATAN_TURNS[i];
					end else begin
						x_s[i+1][l] <= x_s[i][l] + dx;
						y_s[i+1][l] <= y_s[i][l] - dy;
						z_s[i+1][l] <= z_s[i][l] + ATAN_TURNS[i];
					end
					neg_s[i+1][l] <= neg_s[i][l];
				end
			end
		end

		logic signed [XW-1:0] rnd;
		logic signed [XW-1:0] cval;
		// Round Q2.30 to Q16 and restore the sign of the fold.
		assign rnd  = (x_s[CORDIC_STEPS][l] + XW'(8192)) >>> 14;
		assign cval = neg_s[CORDIC_STEPS][l] ? -rnd : rnd;
		always_ff @(posedge clk) begin
			if (en) cos_s[l] <= cval[C_W-1:0];
		end
	end

	assign out_valid = v_s[CORDIC_STEPS+1];
	assign side_out  = side_s[CORDIC_STEPS+1];
	assign cos_a     = cos_s[0];
	assign cos_b     = cos_s[1];

endmodule

// ===== sv/xdw_div.sv =====
// Four-lane restoring divider pipeline, one quotient bit per stage, with overflow flag.
module xdw_div import xdw_pkg::*; #(
	parameter int CW = 52,
	parameter int SIDE_W = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [CW-1:0] num [4],
	input  logic [CW-1:0] den,
	input  logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [QW-1:0] quo [4],
	output logic ovf [4],
	output logic [SIDE_W-1:0] side_out
);

	logic [CW-1:0] rem_s [QW][4];
	logic [QW-1:0] q_s [QW][4];
	logic ovf_s [QW][4];
	logic [CW-1:0] den_s [QW];
	logic v_s [QW];
	logic [SIDE_W-1:0] side_s [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < QW; k++) v_s[k] <= v_s[k-1];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [CW-1:0] d_in;
		logic [SIDE_W-1:0] sd_in;
		if (j == 0) begin : g_first
			assign d_in  = den;
			assign sd_in = side_in;
		end else begin : g_next
			assign d_in  = den_s[j-1];
			assign sd_in = side_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j]  <= d_in;
				side_s[j] <= sd_in;
			end
		end

		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic [CW-1:0] r_in;
			logic [QW-1:0] q_in;
			logic o_in;
			logic [CW-1:0] dsh;
			logic ge;
			if (j == 0) begin : g_first
				assign r_in = num[l];
				assign q_in = '0;
				// A quotient too wide for QW bits saturates downstream.
				assign o_in = num[l] >= (den << QW);
			end else begin : g_next
				assign r_in = rem_s[j-1][l];
				assign q_in = q_s[j-1][l];
				assign o_in = ovf_s[j-1][l];
			end
			assign dsh = d_in << (QW - 1 - j);
			assign ge  = r_in >= dsh;

			// Trial subtraction for one quotient bit.
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j][l] <= ge ? r_in - dsh : r_in;
					q_s[j][l]   <= q_in | (QW'(ge) << (QW - 1 - j));
					ovf_s[j][l] <= o_in;
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign side_out  = side_s[QW-1];
	for (genvar l = 0; l < 4; l++) begin : g_out
		assign quo[l] = q_s[QW-1][l];
		assign ovf[l] = ovf_s[QW-1][l];
	end

endmodule

// ===== sv/x_drive_wheel_mixer_core.sv =====
// Top level of the X-drive wheel mixer: front end, wheel mixing, scaling and output stage.
// A command passes the CORDIC, the wheel mixing, the divider and the output register in that order.
// Throughput: one command per cycle; the whole pipeline advances whenever the
// output register is empty or its result is taken. The 20 CORDIC rotations and the eight
// quotient bits of the divider, one per stage, set the depth.
// Reset clears all valid bits and loads the register reset values.
module x_drive_wheel_mixer_core import xdw_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int SPEED_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	xdw_cfg_if.sink cfg,
	xdw_cmd_if.sink cmd,
	xdw_res_if.source res
);

	localparam int SW = SPEED_FRAC_BITS + 1;
	localparam int PW = SW + 7;
	localparam int DW = MAG_W + SPEED_FRAC_BITS + 1;
	localparam int NW = MAG_W + PW + 2;
	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;
	localparam int CSIDE_W = SW + 8;
	localparam int DSIDE_W = 4 + 2 + 8;

	logic [6:0] max_speed_q;
	logic [6:0] deadband_q;
	logic en;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			deadband_q  <= DEADBAND_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_MAX_SPEED) max_speed_q <= cfg.data;
			if (cfg.index == REG_DEADBAND) deadband_q <= cfg.data;
		end
	end

	logic v_s6;
	assign en        = !v_s6 || res.ready;
	assign cmd.ready = en;

	// Heading turned into the two cosine arguments pi/4 - h and pi/4 + h.
	logic [31:0] h32;
	logic [31:0] ang_a;
	logic [31:0] ang_b;
	assign h32   = 32'(cmd.heading_angle) << (32 - ANGLE_BITS);
	assign ang_a = 32'h2000_0000 - h32;
	assign ang_b = 32'h2000_0000 + h32;

	logic c_valid;
	logic signed [C_W-1:0] ca;
	logic signed [C_W-1:0] cb;
	logic [CSIDE_W-1:0] c_side;

	xdw_cordic #(.SIDE_W(CSIDE_W)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(cmd.valid),
		.ang_a(ang_a), .ang_b(ang_b),
		.side_in({cmd.speed_fraction, cmd.rotation_cmd}),
		.out_valid(c_valid), .cos_a(ca), .cos_b(cb), .side_out(c_side)
	);

	// Stage 2: wheel values, rotation plus or minus m*c, in Q16.
	logic signed [7:0] m_sgn;
	logic signed [W_W-1:0] radd;
	logic signed [W_W-1:0] mca;
	logic signed [W_W-1:0] mcb;
	logic v_s2;
	logic signed [W_W-1:0] w_s2 [4];
	logic [SW-1:0] spd_s2;
	logic signed [7:0] rot_s2;

	assign m_sgn = {1'b0, max_speed_q};
	assign radd  = {{(W_W-24){c_side[7]}}, c_side[7:0], 16'h0000};
	assign mca   = W_W'(m_sgn * ca);
	assign mcb   = W_W'(m_sgn * cb);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2[0] <= mca + {{(W_W-24){c_side[7]}}, c_side[7:0], 16'h0000};
			w_s2[1] <= radd - mcb;
			w_s2[2] <= mcb + {{(W_W-24){c_side[7]}}, c_side[7:0], 16'h0000};
			w_s2[3] <= radd - mca;
			spd_s2  <= c_side[CSIDE_W-1:8];
			rot_s2  <= c_side[7:0];
		end
	end

	// Stage 3: largest positive wheel, magnitudes, speed product and mode.
	logic signed [W_W-1:0] mx01;
	logic signed [W_W-1:0] mx23;
	logic signed [W_W-1:0] mx;
	logic [8:0] rot_abs;
	drive_mode_t mode_c3;
	logic v_s3;
	logic [MAG_W-1:0] wmax_s3;
	logic [MAG_W-1:0] mag_s3 [4];
	logic [3:0] neg_s3;
	logic [PW-1:0] p_s3;
	drive_mode_t mode_s3;
	logic signed [7:0] rot_s3;

	assign mx01    = (w_s2[1] > w_s2[0]) ? w_s2[1] : w_s2[0];
	assign mx23    = (w_s2[3] > w_s2[2]) ? w_s2[3] : w_s2[2];
	assign mx      = (mx23 > mx01) ? mx23 : mx01;
	assign rot_abs = rot_s2[7] ? 9'(-{rot_s2[7], rot_s2}) : {1'b0, rot_s2};

	always_comb begin
		if (spd_s2 != '0) begin
			mode_c3 = (mx > 0) ? MODE_TRANSLATE : MODE_NO_POS;
		end else if (rot_abs > {2'b00, deadband_q}) begin
			mode_c3 = MODE_ROTATE;
		end else begin
			mode_c3 = MODE_BRAKE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wmax_s3 <= (mx > 0) ? mx[MAG_W-1:0] : '0;
			for (int l = 0; l < 4; l++) begin
				mag_s3[l] <= w_s2[l][W_W-1] ? MAG_W'(-w_s2[l]) : w_s2[l][MAG_W-1:0];
				neg_s3[l] <= w_s2[l][W_W-1];
			end
			p_s3    <= PW'(spd_s2 * max_speed_q);
			mode_s3 <= mode_c3;
			rot_s3  <= rot_s2;
		end
	end

	// Stage 4: magnitude times speed product; divisor base.
	logic v_s4;
	logic [MAG_W+PW-1:0] prod_s4 [4];
	logic [DW-2:0] d_s4;
	logic [3:0] neg_s4;
	drive_mode_t mode_s4;
	logic signed [7:0] rot_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) prod_s4[l] <= mag_s3[l] * p_s3;
			d_s4    <= (DW-1)'(wmax_s3) << SPEED_FRAC_BITS;
			neg_s4  <= neg_s3;
			mode_s4 <= mode_s3;
			rot_s4  <= rot_s3;
		end
	end

	// Stage 5: rounding numerator 2*mag*p + d and divisor 2*d.
	logic v_s5;
	logic [CW-1:0] num_s5 [4];
	logic [CW-1:0] den_s5;
	logic [3:0] neg_s5;
	drive_mode_t mode_s5;
	logic signed [7:0] rot_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				num_s5[l] <= (CW'(prod_s4[l]) << 1) + CW'(d_s4);
			end
			// A zero divisor only occurs in the no-positive-wheel case.
			den_s5  <= (d_s4 == '0) ? CW'(1) : (CW'(d_s4) << 1);
			neg_s5  <= neg_s4;
			mode_s5 <= mode_s4;
			rot_s5  <= rot_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= c_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic d_valid;
	logic [QW-1:0] quo [4];
	logic ovf [4];
	logic [DSIDE_W-1:0] d_side;

	xdw_div #(.CW(CW), .SIDE_W(DSIDE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(num_s5), .den(den_s5), .side_in({neg_s5, mode_s5, rot_s5}),
		.out_valid(d_valid), .quo(quo), .ovf(ovf), .side_out(d_side)
	);

	// Output stage: saturate to full scale, apply sign, select by mode.
	drive_mode_t mode_d;
	logic signed [7:0] rot_d;
	logic [3:0] neg_d;
	logic signed [7:0] drv [4];
	logic signed [7:0] drive_s6 [4];
	drive_mode_t mode_s6;

	assign neg_d  = d_side[13:10];
	assign mode_d = drive_mode_t'(d_side[9:8]);
	assign rot_d  = d_side[7:0];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			logic [7:0] qs;
			qs = (ovf[l] || quo[l] > {1'b0, max_speed_q}) ? {1'b0, max_speed_q} : quo[l];
			unique case (mode_d)
				MODE_TRANSLATE: drv[l] = neg_d[l] ? -qs : qs;
				MODE_ROTATE:    drv[l] = rot_d;
				default:        drv[l] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) drive_s6[l] <= drv[l];
			mode_s6 <= mode_d;
		end
	end

	assign res.valid             = v_s6;
	assign res.front_left_drive  = drive_s6[0];
	assign res.front_right_drive = drive_s6[1];
	assign res.rear_left_drive   = drive_s6[2];
	assign res.rear_right_drive  = drive_s6[3];
	assign res.drive_mode        = mode_s6;

endmodule

// ===== sv/xdw_checks.sv =====
// Port-level checks of the X-drive wheel mixer and their binding to the top level.
module xdw_checks import xdw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [7:0] fl,
	input logic [7:0] fr,
	input logic [7:0] rl,
	input logic [7:0] rr,
	input logic [1:0] mode
);

	// A result waiting for transfer keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({fl, fr, rl, rr, mode}))
		else $error("result changed while stalled");

	// With the output register empty the block takes a new command.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command refused while output empty");

	// Brake and the degenerate case drive all wheels to zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (mode == MODE_BRAKE || mode == MODE_NO_POS)
		|-> (fl == 8'd0 && fr == 8'd0 && rl == 8'd0 && rr == 8'd0))
		else $error("nonzero wheel in brake or degenerate result");

	// Rotate-only sends the same value to every wheel.
	a_rot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && mode == MODE_ROTATE |-> (fl == fr && fl == rl && fl == rr))
		else $error("unequal wheels in rotate-only result");

endmodule

bind x_drive_wheel_mixer_core xdw_checks u_xdw_checks (
	.clk(clk), .arst_n(arst_n), .cmd_ready(cmd.ready),
	.res_valid(res.valid), .res_ready(res.ready),
	.fl(res.front_left_drive), .fr(res.front_right_drive),
	.rl(res.rear_left_drive), .rr(res.rear_right_drive), .mode(res.drive_mode)
);
